[rtl/core/crus_pkg.sv]
// Shared types, codes and constants of the cartridge ROM unlock sequencer.
package crus_pkg;

    // Transaction commands
    typedef enum logic [1:0] {
        CMD_IO_READ    = 2'd0,
        CMD_IO_WRITE   = 2'd1,
        CMD_FREEZE     = 2'd2,
        CMD_FREEZE_ACK = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EFFECTS_ENABLE = 3'd0,
        CFG_CART_ATTACHED  = 3'd1,
        CFG_READ_WINDOW    = 3'd2,
        CFG_READ_TRIGGER   = 3'd3,
        CFG_WRITE_WINDOW   = 3'd4,
        CFG_WRITE_TRIGGER  = 3'd5
    } t_cfg_idx;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WINDOW_BITS    = 16;
    localparam int TRIGGER_BITS   = 8;
    localparam int COUNT_BITS     = 8;
    localparam int ADDR_BITS      = 16;
    localparam int STAMP_BITS     = 32;
    localparam int OFFSET_BITS    = 13;

    // Address decode: DF00-DFFF is one page, DE00-DFFF is two pages
    localparam logic [7:0]            IO2_PAGE       = 8'hDF;
    localparam logic [6:0]            IO_PAIR_PAGES  = 7'b1101_111;
    localparam logic [ADDR_BITS-1:0]  UNLOCK_ADDR    = 16'hDF40;
    localparam logic [OFFSET_BITS-1:0] IO2_ROM_BASE  = 13'h1F00;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = 8'hFF;

    // Register reset values
    localparam logic                    RST_EFFECTS_ENABLE = 1'b1;
    localparam logic                    RST_CART_ATTACHED  = 1'b1;
    localparam logic [WINDOW_BITS-1:0]  RST_READ_WINDOW    = 16'd20;
    localparam logic [TRIGGER_BITS-1:0] RST_READ_TRIGGER   = 8'd200;
    localparam logic [WINDOW_BITS-1:0]  RST_WRITE_WINDOW   = 16'd20;
    localparam logic [TRIGGER_BITS-1:0] RST_WRITE_TRIGGER  = 8'd12;

    // Live configuration passed from the register file to the core
    typedef struct packed {
        logic                    effects_enable;
        logic                    cart_attached;
        logic [WINDOW_BITS-1:0]  read_window;
        logic [TRIGGER_BITS-1:0] read_trigger;
        logic [WINDOW_BITS-1:0]  write_window;
        logic [TRIGGER_BITS-1:0] write_trigger;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        logic                   rom_read;
        logic [OFFSET_BITS-1:0] rom_offset;
        logic                   rom_enabled;
        logic                   bank_select;
        logic                   game_line;
        logic                   exrom_line;
        logic                   freeze_interrupt;
    } t_result;

    // Saturating run counter increment
    function automatic logic [COUNT_BITS-1:0] count_bump(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

endpackage

[rtl/core/cartridge_rom_unlock_sequencer.sv]
// Top level of the cartridge ROM unlock sequencer.
//
// Input channel: i_in_valid / o_in_stall carry one bus event per transaction
// (i_cmd, i_bus_address, i_time_stamp). Output channel: o_out_valid /
// i_out_stall carry one result transaction per input transaction, in order.
// A transaction moves at a clock edge with valid high and stall low.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data at any edge with i_cfg_we high; write them only while idle.
//
// An accepted transaction is taken into the input register, then passes
// through the update logic into the result register.
// Throughput: one transaction per cycle while the receiver does not stall;
// the update is combinational: subtract, compare, saturating counter step.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, after which o_in_stall rises until the
// receiver takes the pending result.
// Reset (synchronous, active low) empties both registers, restores the
// configuration defaults and returns the ROM to on, bank 0, no freeze.
module cartridge_rom_unlock_sequencer
    import crus_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_cmd,
    input  logic [ADDR_BITS-1:0]      i_bus_address,
    input  logic [STAMP_BITS-1:0]     i_time_stamp,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_rom_read,
    output logic [OFFSET_BITS-1:0]    o_rom_offset,
    output logic                      o_rom_enabled,
    output logic                      o_bank_select,
    output logic                      o_game_line,
    output logic                      o_exrom_line,
    output logic                      o_freeze_interrupt
);

    t_cfg                 w_cfg;
    t_result              w_result;
    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic [ADDR_BITS-1:0] r_in_addr;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_out_valid;
    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_accept;

    // Handshake between the input register and the result register
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Track register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd  <= t_cmd'(i_cmd);
            r_in_addr <= i_bus_address;
            r_in_now  <= TIME_BITS'(i_time_stamp);
        end
    end

    crus_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    crus_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_advance),
        .i_cmd     (r_in_cmd),
        .i_addr    (r_in_addr),
        .i_now     (r_in_now),
        .o_result  (w_result)
    );

    assign o_out_valid        = r_out_valid;
    assign o_rom_read         = w_result.rom_read;
    assign o_rom_offset       = w_result.rom_offset;
    assign o_rom_enabled      = w_result.rom_enabled;
    assign o_bank_select      = w_result.bank_select;
    assign o_game_line        = w_result.game_line;
    assign o_exrom_line       = w_result.exrom_line;
    assign o_freeze_interrupt = w_result.freeze_interrupt;

endmodule

[rtl/core/crus_cfg_regs.sv]
// Configuration register file of the cartridge ROM unlock sequencer.
module crus_cfg_regs
    import crus_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EFFECTS_ENABLE: n_cfg.effects_enable = i_cfg_data[0];
                CFG_CART_ATTACHED:  n_cfg.cart_attached  = i_cfg_data[0];
                CFG_READ_WINDOW:    n_cfg.read_window    = i_cfg_data[WINDOW_BITS-1:0];
                CFG_READ_TRIGGER:   n_cfg.read_trigger   = i_cfg_data[TRIGGER_BITS-1:0];
                CFG_WRITE_WINDOW:   n_cfg.write_window   = i_cfg_data[WINDOW_BITS-1:0];
                CFG_WRITE_TRIGGER:  n_cfg.write_trigger  = i_cfg_data[TRIGGER_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effects_enable <= RST_EFFECTS_ENABLE;
            r_cfg.cart_attached  <= RST_CART_ATTACHED;
            r_cfg.read_window    <= RST_READ_WINDOW;
            r_cfg.read_trigger   <= RST_READ_TRIGGER;
            r_cfg.write_window   <= RST_WRITE_WINDOW;
            r_cfg.write_trigger  <= RST_WRITE_TRIGGER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/crus_core.sv]
// Sequencer state, per-transaction update logic and result register.
module crus_core
    import crus_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_advance,
    input  t_cmd                 i_cmd,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [TIME_BITS-1:0] i_now,
    output t_result              o_result
);

    logic                   r_rom_on,      n_rom_on;
    logic [COUNT_BITS-1:0]  r_wr_cnt,      n_wr_cnt;
    logic [COUNT_BITS-1:0]  r_rd_cnt,      n_rd_cnt;
    logic [TIME_BITS-1:0]   r_last_wr,     n_last_wr;
    logic [TIME_BITS-1:0]   r_last_rd,     n_last_rd;
    logic                   r_bank,        n_bank;
    logic                   r_pending,     n_pending;
    logic                   r_game,        n_game;
    logic                   r_exrom,       n_exrom;
    t_result                r_result,      n_result;

    logic [TIME_BITS-1:0]   w_rd_gap;
    logic [TIME_BITS-1:0]   w_wr_gap;
    logic                   w_rd_near;
    logic                   w_wr_near;
    logic [COUNT_BITS-1:0]  w_rd_bump;
    logic [COUNT_BITS-1:0]  w_wr_bump;
    logic                   w_io2_page;
    logic                   w_io_pair;

    // Gaps since the last counted accesses; a negative gap counts as near
    assign w_rd_gap  = i_now - r_last_rd;
    assign w_wr_gap  = i_now - r_last_wr;
    assign w_rd_near = w_rd_gap[TIME_BITS-1] ||
                       (w_rd_gap <= TIME_BITS'(i_cfg.read_window));
    assign w_wr_near = w_wr_gap[TIME_BITS-1] ||
                       (w_wr_gap <= TIME_BITS'(i_cfg.write_window));
    assign w_rd_bump = count_bump(r_rd_cnt);
    assign w_wr_bump = count_bump(r_wr_cnt);

    assign w_io2_page = (i_addr[15:8] == IO2_PAGE);
    assign w_io_pair  = (i_addr[15:9] == IO_PAIR_PAGES);

    // Update state for the transaction in the input register
    always_comb begin
        n_rom_on  = r_rom_on;
        n_wr_cnt  = r_wr_cnt;
        n_rd_cnt  = r_rd_cnt;
        n_last_wr = r_last_wr;
        n_last_rd = r_last_rd;
        n_bank    = r_bank;
        n_pending = r_pending;
        n_game    = r_game;
        n_exrom   = r_exrom;
        n_result  = '0;

        unique case (i_cmd)
            CMD_IO_READ: begin
                if (i_cfg.effects_enable && !w_rd_near) begin
                    n_rd_cnt = '0;
                end
                if (w_io2_page) begin
                    if (i_cfg.effects_enable && (i_addr == UNLOCK_ADDR)) begin
                        if (w_rd_near) begin
                            if (w_rd_bump > i_cfg.read_trigger) begin
                                n_rd_cnt = '0;
                                n_rom_on = 1'b0;
                            end else begin
                                n_rd_cnt = w_rd_bump;
                            end
                        end
                        n_last_rd = i_now;
                    end
                    n_result.rom_read   = 1'b1;
                    n_result.rom_offset = IO2_ROM_BASE | OFFSET_BITS'(i_addr[7:0]);
                end
            end
            CMD_IO_WRITE: begin
                if (w_io_pair) begin
                    n_rd_cnt = '0;
                    if (w_wr_near) begin
                        if (w_wr_bump > i_cfg.write_trigger) begin
                            n_wr_cnt = '0;
                            n_rom_on = 1'b1;
                            n_bank   = 1'b1;
                        end else begin
                            n_wr_cnt = w_wr_bump;
                        end
                    end else begin
                        n_wr_cnt = '0;
                    end
                    n_last_wr = i_now;
                end
            end
            CMD_FREEZE: begin
                if (i_cfg.cart_attached) begin
                    n_pending = 1'b1;
                end
            end
            CMD_FREEZE_ACK: begin
                if (r_pending) begin
                    n_bank    = 1'b0;
                    n_pending = 1'b0;
                end
            end
        endcase

        // Drive the lines from the ROM state unless a freeze holds them
        if (!n_pending) begin
            if (!n_rom_on) begin
                n_game  = 1'b1;
                n_exrom = 1'b1;
            end else if (!n_bank) begin
                n_game  = 1'b0;
                n_exrom = 1'b1;
            end else begin
                n_game  = 1'b1;
                n_exrom = 1'b0;
            end
        end

        n_result.rom_enabled      = n_rom_on;
        n_result.bank_select      = n_bank;
        n_result.game_line        = n_game;
        n_result.exrom_line       = n_exrom;
        n_result.freeze_interrupt = n_pending;
    end

    // Commit state on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_on  <= 1'b1;
            r_wr_cnt  <= '0;
            r_rd_cnt  <= '0;
            r_last_wr <= '0;
            r_last_rd <= '0;
            r_bank    <= 1'b0;
            r_pending <= 1'b0;
            r_game    <= 1'b0;
            r_exrom   <= 1'b1;
        end else if (i_advance) begin
            r_rom_on  <= n_rom_on;
            r_wr_cnt  <= n_wr_cnt;
            r_rd_cnt  <= n_rd_cnt;
            r_last_wr <= n_last_wr;
            r_last_rd <= n_last_rd;
            r_bank    <= n_bank;
            r_pending <= n_pending;
            r_game    <= n_game;
            r_exrom   <= n_exrom;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

[rtl/core/crus_checker.sv]
// Port-level checker of the cartridge ROM unlock sequencer and its bind.
module crus_checker
    import crus_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic                      o_rom_read,
    input  logic [OFFSET_BITS-1:0]    o_rom_offset,
    input  logic                      o_rom_enabled,
    input  logic                      o_bank_select,
    input  logic                      o_game_line,
    input  logic                      o_exrom_line,
    input  logic                      o_freeze_interrupt
);

    // Reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result transaction present right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_rom_read) && $stable(o_rom_offset) &&
            $stable(o_rom_enabled) && $stable(o_bank_select) &&
            $stable(o_game_line) && $stable(o_exrom_line) &&
            $stable(o_freeze_interrupt))
        else $error("stalled result transaction changed");

    // GAME and EXROM are never both low
    a_lines_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_game_line || o_exrom_line))
        else $error("GAME and EXROM both low");

    // Non-ROM reads carry a zero offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rom_read |-> (o_rom_offset == '0))
        else $error("offset set without a ROM read");

    // ROM reads land in the top page of the bank
    a_offset_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rom_read |->
            (o_rom_offset[OFFSET_BITS-1:8] == IO2_ROM_BASE[OFFSET_BITS-1:8]))
        else $error("ROM read offset outside the IO2 page");

endmodule

bind cartridge_rom_unlock_sequencer crus_checker u_crus_checker (.*);
